>>> design/oaa_pkg.sv
// Shared widths, octant bases and pipeline payload types for the atan2 approximation.
`timescale 1ns / 1ps

package oaa_pkg;

  localparam int COORD_BITS = 23;
  localparam int MAG_W      = COORD_BITS;      // |coord| up to 2^(COORD_BITS-1)
  localparam int REM_W      = MAG_W + 1;       // partial remainder, < 2*divisor
  localparam int QUO_W      = 10;              // ratio 0..512
  localparam int ANGLE_W    = 13;              // angle 0..4096
  localparam int IN_TDATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ANGLE_W + 7) / 8) * 8;

  localparam logic [ANGLE_W-1:0] BASE_0    = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0] BASE_1024 = ANGLE_W'(1024);
  localparam logic [ANGLE_W-1:0] BASE_2048 = ANGLE_W'(2048);
  localparam logic [ANGLE_W-1:0] BASE_3072 = ANGLE_W'(3072);
  localparam logic [ANGLE_W-1:0] BASE_4096 = ANGLE_W'(4096);

  // Octant decision: base angle and whether the ratio is subtracted from it.
  typedef struct packed {
    logic               sub;
    logic [ANGLE_W-1:0] base;
  } ctl_t;

  // Payload of one divider stage.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] divisor;
    logic [QUO_W-1:0] quo;
    ctl_t             ctl;
  } div_t;

endpackage

>>> design/oaa_div_stage.sv
// One restoring-division stage: resolves one quotient bit, registered.
`timescale 1ns / 1ps

module oaa_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  oaa_pkg::div_t in_data,
  output logic          out_valid,
  output oaa_pkg::div_t out_data
);

  logic [oaa_pkg::REM_W:0]   diff;
  logic                      ge;
  logic [oaa_pkg::REM_W-1:0] rem_sub;
  oaa_pkg::div_t             data_next;

  always_comb begin
    diff    = {1'b0, in_data.rem} - {2'b00, in_data.divisor};
    ge      = ~diff[oaa_pkg::REM_W];
    rem_sub = ge ? diff[oaa_pkg::REM_W-1:0] : in_data.rem;
    data_next       = in_data;
    data_next.rem   = {rem_sub[oaa_pkg::REM_W-2:0], 1'b0};
    data_next.quo   = {in_data.quo[oaa_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

>>> design/octant_atan2_approx.sv
// Top level: pipelined octant-linear atan2 approximation, 4096 units per turn.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_axis_*): one item per coordinate pair, coord_y in tdata
//   [22:0], coord_x in tdata[45:23], both two's complement; tdata[47:46] unused.
//   Output stream (m_axis_*): one item per input item, angle in tdata[12:0],
//   0..4096 counterclockwise from +x (4096 is kept, not wrapped).
// Throughput: one item per cycle, sustained while the output is not stalled.
// Pipeline: 13 register stages from the accepting edge to m_axis_tvalid:
//   magnitudes and signs, magnitude compare and octant select, ten
//   restoring divider stages (one quotient bit per stage, the ratio
//   small*512/large), and the base add/subtract.
// Stall: every stage advances together while the output register is empty
//   or being taken; when m_axis_tready is low with a result held, the whole
//   pipeline freezes and s_axis_tready drops, so nothing is lost or repeated.
//   Bubbles travel as invalid stages.
// Reset: rst (synchronous) clears all valid bits; no item is in flight.

module octant_atan2_approx (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [22:0] coord_y, [45:23] coord_x, [47:46] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [12:0] angle, [15:13] zero
);

  localparam int CB = oaa_pkg::COORD_BITS;

  logic en;

  // Whole pipeline moves when the output slot is free or being drained.
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  // ---- stage 0: signs and magnitudes --------------------------------------
  logic signed [CB-1:0]   in_y, in_x;
  logic [oaa_pkg::MAG_W-1:0] ax_c, ay_c;

  assign in_y = s_axis_tdata[CB-1:0];
  assign in_x = s_axis_tdata[2*CB-1:CB];

  always_comb begin
    // x of zero counts as +1
    if (in_x == '0) begin
      ax_c = oaa_pkg::MAG_W'(1);
    end else if (in_x[CB-1]) begin
      ax_c = oaa_pkg::MAG_W'(-in_x);
    end else begin
      ax_c = oaa_pkg::MAG_W'(in_x);
    end
    ay_c = in_y[CB-1] ? oaa_pkg::MAG_W'(-in_y) : oaa_pkg::MAG_W'(in_y);
  end

  logic                      s0_valid;
  logic [oaa_pkg::MAG_W-1:0] s0_ax, s0_ay;
  logic                      s0_x_neg, s0_y_neg, s0_y_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ax     <= ax_c;
      s0_ay     <= ay_c;
      s0_x_neg  <= in_x[CB-1];
      s0_y_neg  <= in_y[CB-1];
      s0_y_zero <= (in_y == '0);
    end
  end

  // ---- stage 1: compare, octant select, divider operands ------------------
  logic                      ax_lt_ay, ay_lt_ax;
  logic                      by_y;     // ratio is |x|*512/|y|
  oaa_pkg::ctl_t             ctl_c;
  oaa_pkg::div_t             div_c;

  always_comb begin
    ax_lt_ay = s0_ax < s0_ay;
    ay_lt_ax = s0_ay < s0_ax;
    by_y     = 1'b0;
    ctl_c    = oaa_pkg::ctl_t'{sub: 1'b0, base: oaa_pkg::BASE_0};
    if (s0_y_zero) begin
      // on the x axis: ratio forced to 0 (small = |y| = 0)
      by_y       = 1'b0;
      ctl_c.base = s0_x_neg ? oaa_pkg::BASE_2048 : oaa_pkg::BASE_0;
    end else begin
      case ({s0_x_neg, s0_y_neg})
        2'b00: begin
          by_y  = ax_lt_ay;
          ctl_c = ax_lt_ay ? oaa_pkg::ctl_t'{sub: 1'b1, base: oaa_pkg::BASE_1024}
                           : oaa_pkg::ctl_t'{sub: 1'b0, base: oaa_pkg::BASE_0};
        end
        2'b01: begin
          by_y  = ~ay_lt_ax;
          ctl_c = ay_lt_ax ? oaa_pkg::ctl_t'{sub: 1'b1, base: oaa_pkg::BASE_4096}
                           : oaa_pkg::ctl_t'{sub: 1'b0, base: oaa_pkg::BASE_3072};
        end
        2'b10: begin
          by_y  = ax_lt_ay;
          ctl_c = ax_lt_ay ? oaa_pkg::ctl_t'{sub: 1'b0, base: oaa_pkg::BASE_1024}
                           : oaa_pkg::ctl_t'{sub: 1'b1, base: oaa_pkg::BASE_2048};
        end
        default: begin
          by_y  = ~ay_lt_ax;
          ctl_c = ay_lt_ax ? oaa_pkg::ctl_t'{sub: 1'b0, base: oaa_pkg::BASE_2048}
                           : oaa_pkg::ctl_t'{sub: 1'b1, base: oaa_pkg::BASE_3072};
        end
      endcase
    end
    div_c.rem     = by_y ? oaa_pkg::REM_W'(s0_ax) : oaa_pkg::REM_W'(s0_ay);
    div_c.divisor = by_y ? s0_ay : s0_ax;
    div_c.quo     = '0;
    div_c.ctl     = ctl_c;
  end

  // ---- divider chain: one quotient bit per stage, MSB first ---------------
  logic          div_valid [oaa_pkg::QUO_W+1];
  oaa_pkg::div_t div_data  [oaa_pkg::QUO_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else if (en) begin
      div_valid[0] <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_data[0] <= div_c;
    end
  end

  for (genvar k = 0; k < oaa_pkg::QUO_W; k++) begin : g_div
    oaa_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (div_valid[k]),
      .in_data   (div_data[k]),
      .out_valid (div_valid[k+1]),
      .out_data  (div_data[k+1])
    );
  end

  // ---- output stage: base +/- ratio ---------------------------------------
  oaa_pkg::div_t               fin;
  logic [oaa_pkg::ANGLE_W-1:0] ratio_ext;
  logic [oaa_pkg::ANGLE_W-1:0] angle_c;
  logic [oaa_pkg::ANGLE_W-1:0] angle;

  assign fin       = div_data[oaa_pkg::QUO_W];
  assign ratio_ext = oaa_pkg::ANGLE_W'(fin.quo);
  assign angle_c   = fin.ctl.sub ? fin.ctl.base - ratio_ext : fin.ctl.base + ratio_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= div_valid[oaa_pkg::QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= angle_c;
    end
  end

  assign m_axis_tdata = {(oaa_pkg::OUT_TDATA_W - oaa_pkg::ANGLE_W)'(0), angle};

endmodule
